// ===== hw/rtl/srdq_pkg.sv =====
// shared types and constants for the shift register deque
`default_nettype none

package srdq_pkg;

  // number of cells in the chain
  localparam int DEPTH = 16;
  // width of the fill count, wide enough to hold DEPTH itself
  localparam int CNT_W = $clog2(DEPTH + 1);
  // width of the capacity register field
  localparam int CAP_W = 5;
  // common width for comparing the count against the capacity
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // request codes
  localparam logic [1:0] REQ_ADD_FRONT = 2'd0;
  localparam logic [1:0] REQ_ADD_END   = 2'd1;
  localparam logic [1:0] REQ_REM_FRONT = 2'd2;
  localparam logic [1:0] REQ_REM_END   = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] removed_value;
    logic [4:0]               item_count;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
  } out_item_t;

  // operation broadcast to every cell, at most one bit set
  typedef struct packed {
    logic add_front;
    logic add_end;
    logic rem_front;
    logic rem_end;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srdq_cell.sv =====
// one cell of the deque chain: a stored value and a tail marker
`default_nettype none

module srdq_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire srdq_pkg::cell_ctl_t               ctl,
  input  wire logic signed [srdq_pkg::DATA_W-1:0] value,
  input  wire logic signed [srdq_pkg::DATA_W-1:0] left_data,
  input  wire logic                              left_tail,
  input  wire logic signed [srdq_pkg::DATA_W-1:0] right_data,
  input  wire logic                              right_tail,
  output logic signed [srdq_pkg::DATA_W-1:0]      data,
  output logic                                   tail,
  output logic signed [srdq_pkg::DATA_W-1:0]      data_next,
  output logic                                   tail_next
);

  // next contents from the neighbors; tail marks the last stored value
  always_comb begin
    data_next = data;
    tail_next = tail;
    if (ctl.add_front) begin
      data_next = left_data;
      tail_next = left_tail;
    end else if (ctl.add_end) begin
      // the cell just past the tail takes the new value
      if (left_tail) begin
        data_next = value;
      end
      tail_next = left_tail;
    end else if (ctl.rem_front) begin
      data_next = right_data;
      tail_next = right_tail;
    end else if (ctl.rem_end) begin
      if (tail) begin
        data_next = '0;
      end
      tail_next = right_tail;
    end
  end

  // cell storage, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
      tail <= 1'b0;
    end else begin
      data <= data_next;
      tail <= tail_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/shift_register_deque_core.sv =====
// Shift register deque: a chain of cells that all update together on each accepted item.
// Result: registered in the output register when the item is accepted.
// Throughput: one item per cycle while the output is not stalled; every cell loads from its neighbor in parallel.
// Reset: all cells cleared to zero, list empty, capacity set to 16.
`default_nettype none

module shift_register_deque_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [srdq_pkg::CAP_W-1:0]      cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire srdq_pkg::in_item_t              in_item,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output srdq_pkg::out_item_t                  out_item
);

  localparam int D = srdq_pkg::DEPTH;
  localparam int W = srdq_pkg::DATA_W;

  logic [srdq_pkg::CAP_W-1:0] capacity;
  logic [srdq_pkg::CNT_W-1:0] count;
  logic [srdq_pkg::CNT_W-1:0] count_next;
  logic                       accept;
  logic                       empty;
  logic                       full;
  logic [srdq_pkg::CMP_W-1:0] cap_ext;
  logic [srdq_pkg::CMP_W-1:0] cnt_ext;
  logic [srdq_pkg::CMP_W-1:0] eff_cap;
  logic [1:0]                 status;
  logic signed [W-1:0]        removed;
  logic signed [W-1:0]        back_now;
  logic signed [W-1:0]        back_next;
  srdq_pkg::cell_ctl_t        ctl;

  logic signed [W-1:0] cell_data [D];
  logic signed [W-1:0] cell_data_next [D];
  logic                cell_tail [D];
  logic                cell_tail_next [D];

  // output register frees up whenever it is empty or being taken
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // capacity limited to the chain depth
  assign cap_ext = srdq_pkg::CMP_W'(capacity);
  assign cnt_ext = srdq_pkg::CMP_W'(count);
  assign eff_cap = (cap_ext > srdq_pkg::CMP_W'(D)) ? srdq_pkg::CMP_W'(D) : cap_ext;
  assign full    = cnt_ext >= eff_cap;
  assign empty   = (count == '0);

  // decode the request into a cell operation and a status
  always_comb begin
    ctl        = '0;
    status     = srdq_pkg::ST_DONE;
    count_next = count;
    unique case (in_item.req_type)
      srdq_pkg::REQ_ADD_FRONT,
      srdq_pkg::REQ_ADD_END: begin
        if (full) begin
          status = srdq_pkg::ST_FULL;
        end else begin
          ctl.add_front = accept && (in_item.req_type == srdq_pkg::REQ_ADD_FRONT);
          ctl.add_end   = accept && (in_item.req_type == srdq_pkg::REQ_ADD_END);
          count_next    = count + 1'b1;
        end
      end
      srdq_pkg::REQ_REM_FRONT,
      srdq_pkg::REQ_REM_END: begin
        if (empty) begin
          status = srdq_pkg::ST_EMPTY;
        end else begin
          ctl.rem_front = accept && (in_item.req_type == srdq_pkg::REQ_REM_FRONT);
          ctl.rem_end   = accept && (in_item.req_type == srdq_pkg::REQ_REM_END);
          count_next    = count - 1'b1;
        end
      end
      default: begin
        status = srdq_pkg::ST_DONE;
      end
    endcase
  end

  // chain of cells, neighbors wired left to right
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic signed [W-1:0] left_d;
    logic                left_t;
    logic signed [W-1:0] right_d;
    logic                right_t;

    if (i == 0) begin : g_first
      assign left_d = in_item.value;
      assign left_t = empty;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
      assign left_t = cell_tail[i-1];
    end

    if (i == D - 1) begin : g_last
      assign right_d = '0;
      assign right_t = 1'b0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
      assign right_t = cell_tail[i+1];
    end

    srdq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .value      (in_item.value),
      .left_data  (left_d),
      .left_tail  (left_t),
      .right_data (right_d),
      .right_tail (right_t),
      .data       (cell_data[i]),
      .tail       (cell_tail[i]),
      .data_next  (cell_data_next[i]),
      .tail_next  (cell_tail_next[i])
    );
  end

  // back value now and after the update, picked by the tail marker
  always_comb begin
    back_now  = '0;
    back_next = '0;
    for (int i = 0; i < D; i++) begin
      back_now  = back_now  | (cell_tail[i]      ? cell_data[i]      : '0);
      back_next = back_next | (cell_tail_next[i] ? cell_data_next[i] : '0);
    end
  end

  // value taken out by a removal
  always_comb begin
    removed = '0;
    if (status == srdq_pkg::ST_DONE) begin
      if (in_item.req_type == srdq_pkg::REQ_REM_FRONT) begin
        removed = cell_data[0];
      end else if (in_item.req_type == srdq_pkg::REQ_REM_END) begin
        removed = back_now;
      end
    end
  end

  // capacity register and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= srdq_pkg::CAP_RESET;
      count    <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item.status        <= status;
      out_item.removed_value <= removed;
      out_item.item_count    <= 5'(count_next);
      out_item.front_value   <= (count_next == '0) ? '0 : cell_data_next[0];
      out_item.back_value    <= back_next;
    end
  end

endmodule

`default_nettype wire
